// ===== hw/rtl/dvf_pkg.sv =====
package dvf_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned CountW = 7;

	typedef logic signed [ValueW-1:0] value_t;

	typedef struct packed {
		value_t value;
		logic   last_of_set;
	} item_t;

	typedef struct packed {
		value_t            value_out;
		logic              first_seen;
		logic              overflow;
		logic [CountW-1:0] distinct_count;
		logic              set_done;
	} result_t;

endpackage

// ===== hw/rtl/dvf_item_if.sv =====
interface dvf_item_if;
	logic           valid;
	logic           ready;
	dvf_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dvf_result_if.sv =====
interface dvf_result_if;
	logic             valid;
	logic             ready;
	dvf_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/distinct_value_filter.sv =====
// Flags repeated values in a stream of 32-bit signed values grouped into sets. Every input
// transaction gives exactly one result transaction that echoes the value, says whether it is new
// to the current set, flags a new value that found the table full, and carries the running count
// of stored distinct values; the input marked as the last of its set empties the table after its
// result. Stored values sit in a single-port-read memory of TABLE_DEPTH entries that is scanned
// one entry per cycle, oldest first, and the scan stops at the first match. A new item is not
// taken until the scan of the last one has ended and its result has been loaded, so items are
// handled one at a time, limited by that one read port. A finished result waits in an output
// register, so the next item is taken while it is still pending.
module distinct_value_filter #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	dvf_item_if.sink    items,
	dvf_result_if.source results
);
	import dvf_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DepthCount = CW'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          rd_pend_s1;
	logic          found_q;
	logic          out_valid_q;
	result_t       out_q;
	value_t        value_q;
	logic          last_q;
	value_t        rdata_s1;
	value_t        table_mem [TABLE_DEPTH];

	logic          accept;
	logic          match;
	logic          more;
	logic          rd_en;
	logic          out_free;
	logic          finish;
	logic          room;
	logic          store;
	logic [CW-1:0] cnt_after;

	assign accept    = items.valid && items.ready;
	assign match     = rd_pend_s1 && (rdata_s1 == value_q);
	assign more      = idx_q < cnt_q;
	assign rd_en     = (state_q == ST_SCAN) && !match && more;
	assign out_free  = !out_valid_q || results.ready;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign room      = cnt_q < DepthCount;
	assign store     = !found_q && room;
	assign cnt_after = cnt_q + CW'(store);

	assign items.ready     = (state_q == ST_IDLE);
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						found_q    <= 1'b1;
						rd_pend_s1 <= 1'b0;
						state_q    <= ST_FINISH;
					end else if (more) begin
						idx_q      <= idx_q + CW'(1);
						rd_pend_s1 <= 1'b1;
					end else begin
						found_q    <= 1'b0;
						rd_pend_s1 <= 1'b0;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						cnt_q   <= last_q ? '0 : cnt_after;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= items.payload.value;
			last_q  <= items.payload.last_of_set;
		end
		if (finish) begin
			out_q.value_out      <= value_q;
			out_q.first_seen     <= !found_q;
			out_q.overflow       <= !found_q && !room;
			out_q.distinct_count <= CountW'(cnt_after);
			out_q.set_done       <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && store) begin
			table_mem[cnt_q[AW-1:0]] <= value_q;
		end
		if (rd_en) begin
			rdata_s1 <= table_mem[idx_q[AW-1:0]];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DepthCount)
		else $error("stored count exceeds the table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= cnt_q))
		else $error("scan index ran past the stored entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("read data pending outside a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result loaded without a finished scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.overflow && !out_q.first_seen))
		else $error("overflow flagged on a duplicate");

endmodule

// ===== tb/distinct_value_filter_tb.sv =====
module distinct_value_filter_tb;
	import dvf_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned ITEM_TARGET = 1000;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned HOLD_OFF_CYCLES = 500;
	localparam int unsigned MAX_REPORTS = 40;
	localparam int unsigned BUSY_PCT = 51;
	localparam int unsigned BOTH_PCT = 18;
	localparam value_t VMIN = 32'sh8000_0000;
	localparam value_t VMAX = 32'sh7FFF_FFFF;

	class dedup_checker;
		value_t seen_vals[TABLE_DEPTH];
		int unsigned n_stored;
		result_t expected_verdicts[$];
		int unsigned n_errors;
		int unsigned n_checked;
		int unsigned n_sets;
		int unsigned n_repeats;
		int unsigned n_overflows;

		function result_t classify(item_t it);
			result_t r;
			bit hit;
			hit = 1'b0;
			for (int unsigned k = 0; k < n_stored; k++) begin
				if (seen_vals[k] == it.value) begin
					hit = 1'b1;
					break;
				end
			end
			r.value_out = it.value;
			r.first_seen = !hit;
			r.overflow = 1'b0;
			if (hit) begin
				n_repeats++;
			end else if (n_stored < TABLE_DEPTH) begin
				seen_vals[n_stored] = it.value;
				n_stored++;
			end else begin
				r.overflow = 1'b1;
				n_overflows++;
			end
			r.distinct_count = CountW'(n_stored);
			r.set_done = it.last_of_set;
			if (it.last_of_set) begin
				n_stored = 0;
				n_sets++;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			expected_verdicts.push_back(classify(it));
		endfunction

		function int unsigned pending();
			return expected_verdicts.size();
		endfunction

		task report(string msg);
			if (n_errors < MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			n_errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_verdicts.size() == 0) begin
				report($sformatf("result transaction with nothing expected, value %0d",
					got.value_out));
				return;
			end
			want = expected_verdicts.pop_front();
			n_checked++;
			if (got.value_out !== want.value_out)
				report($sformatf("value_out %0d, expected %0d", got.value_out, want.value_out));
			if (got.first_seen !== want.first_seen)
				report($sformatf("first_seen %b, expected %b for value %0d",
					got.first_seen, want.first_seen, want.value_out));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %b, expected %b for value %0d",
					got.overflow, want.overflow, want.value_out));
			if (got.distinct_count !== want.distinct_count)
				report($sformatf("distinct_count %0d, expected %0d for value %0d",
					got.distinct_count, want.distinct_count, want.value_out));
			if (got.set_done !== want.set_done)
				report($sformatf("set_done %b, expected %b for value %0d",
					got.set_done, want.set_done, want.value_out));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	dvf_item_if items_if();
	dvf_result_if results_if();
	dedup_checker dedup = new();

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit hold_off_req = 1'b0;
	int unsigned n_sent = 0;
	int unsigned quiet_cycles = 0;

	distinct_value_filter #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready)
				dedup.check_result(results_if.payload);
			if (items_if.valid && items_if.ready)
				dedup.note_item(items_if.payload);
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog expired after %0d cycles without a transaction", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic drive_item(input value_t v, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			items_if.valid <= 1'b0;
		end
		@(negedge clk);
		items_if.valid <= 1'b1;
		items_if.payload <= '{value: v, last_of_set: is_last};
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		items_if.valid <= 1'b0;
		while (dedup.pending() != 0) @(posedge clk);
	endtask

	task automatic send_random_set();
		value_t pool[$];
		value_t v;
		int unsigned kind;
		int unsigned len;
		logic is_last;
		kind = $urandom_range(9);
		if (kind <= 1) begin
			len = $urandom_range(TABLE_DEPTH + 24, TABLE_DEPTH + 40);
		end else if (kind <= 7) begin
			len = $urandom_range(1, 20);
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(4))
					0: pool.push_back(VMIN);
					1: pool.push_back(VMAX);
					2: pool.push_back('0);
					3: pool.push_back('1);
					default: pool.push_back($urandom);
				endcase
			end
		end else begin
			len = $urandom_range(1, 12);
		end
		for (int unsigned i = 0; i < len; i++) begin
			is_last = (i == len - 1);
			if (kind <= 1) begin
				if (pool.size() != 0 && $urandom_range(3) == 0) begin
					v = pool[$urandom_range(pool.size() - 1)];
				end else begin
					v = $urandom;
					pool.push_back(v);
				end
			end else if (kind <= 7) begin
				v = pool[$urandom_range(pool.size() - 1)];
			end else begin
				v = $urandom;
				is_last = is_last || ($urandom_range(3) == 0);
			end
			drive_item(v, is_last);
		end
	endtask

	initial begin
		value_t base;
		int unsigned set_no;
		items_if.valid = 1'b0;
		items_if.payload = '0;
		results_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		drive_item(VMIN, 1'b0);
		drive_item(VMAX, 1'b0);
		drive_item('0, 1'b0);
		drive_item('1, 1'b0);
		drive_item(VMIN, 1'b0);
		drive_item(VMAX, 1'b0);
		drive_item(32'sd1, 1'b0);
		drive_item('0, 1'b1);
		drive_item('0, 1'b1);
		drive_item(32'sh5555_5555, 1'b0);
		drive_item(32'shAAAA_AAAA, 1'b0);
		drive_item(32'sh5555_5555, 1'b0);
		drive_item(32'shAAAA_AAAA, 1'b1);
		drive_item('1, 1'b1);

		// Fill the table exactly, then push an unseen value twice and two repeats against a full table.
		base = $urandom;
		for (int k = 0; k < TABLE_DEPTH; k++)
			drive_item(base + k, 1'b0);
		drive_item(base + TABLE_DEPTH, 1'b0);
		drive_item(base + TABLE_DEPTH, 1'b0);
		drive_item(base, 1'b0);
		drive_item(base + TABLE_DEPTH - 1, 1'b1);

		set_no = 0;
		while (n_sent < ITEM_TARGET) begin
			case ((n_sent / 100) % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = BUSY_PCT;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = BUSY_PCT;
				end
				default: begin
					send_idle_pct = BOTH_PCT;
					stall_pct = BOTH_PCT;
				end
			endcase
			if (set_no == 3)
				hold_off_req = 1'b1;
			if (set_no == 12 || set_no == 25)
				wait_drained();
			send_random_set();
			set_no++;
		end

		wait_drained();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		$display("Covered %0d input transactions in %0d sets, %0d results checked.",
			n_sent, dedup.n_sets, dedup.n_checked);
		$display("Saw %0d repeated values and %0d new values that met a full table.",
			dedup.n_repeats, dedup.n_overflows);
		if (dedup.n_errors == 0 && dedup.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", dedup.n_errors,
				dedup.pending());
			$display("status: fail");
		end
		$finish;
	end
endmodule
